// ===== design/lmc_pkg.sv =====
package lmc_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_BARGRAPH = 3'd1,
    MODE_WHITE    = 3'd2,
    MODE_RED      = 3'd3,
    MODE_FADE     = 3'd4,
    MODE_WAIT     = 3'd5
  } lamp_mode_e;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 10;

  localparam logic [CfgIdxW-1:0] CFG_FADE_INTERVAL = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FADE_FLOOR    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ON_BRIGHTNESS = 2'd2;

  localparam logic [7:0] FADE_INTERVAL_RST = 8'd10;
  localparam logic [7:0] FADE_FLOOR_RST    = 8'd30;
  localparam logic [9:0] ON_BRIGHTNESS_RST = 10'd1023;

  localparam logic [7:0] FADE_TOP = 8'd255;
  localparam logic [7:0] ELAPSED_MAX = 8'd255;

  localparam logic [18:0] CV_SCALE = 19'd440;
  localparam logic [8:0] CV_LEVEL1 = 9'd320;
  localparam logic [8:0] CV_LEVEL2 = 9'd340;
  localparam logic [8:0] CV_LEVEL3 = 9'd360;
  localparam logic [8:0] CV_LEVEL4 = 9'd370;
  localparam logic [8:0] CV_LEVEL5 = 9'd400;

  typedef struct packed {
    logic [7:0] fade_interval_ms;
    logic [7:0] fade_floor_index;
    logic [9:0] on_brightness;
  } cfg_t;

  typedef struct packed {
    logic       press_event;
    logic       release_event;
    logic       long_press;
    logic [9:0] battery_code;
  } tick_t;

  typedef struct packed {
    lamp_mode_e mode;
    logic       white_enable;
    logic [9:0] white_level;
    logic       red_enable;
    logic       bargraph_enable;
    logic [2:0] bargraph_level;
  } result_t;

  localparam logic [9:0] GAMMA_ROM [256] = '{
    10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,
    10'd1,   10'd1,   10'd1,   10'd1,   10'd1,   10'd2,   10'd2,
    10'd2,   10'd3,   10'd3,   10'd3,   10'd4,   10'd4,   10'd5,   10'd5,
    10'd5,   10'd6,   10'd7,   10'd7,   10'd8,   10'd8,   10'd9,
    10'd10,  10'd10,  10'd11,  10'd12,  10'd13,  10'd13,  10'd14,  10'd15,
    10'd16,  10'd17,  10'd18,  10'd19,  10'd20,  10'd21,  10'd22,
    10'd23,  10'd24,  10'd25,  10'd27,  10'd28,  10'd29,  10'd30,  10'd32,
    10'd33,  10'd34,  10'd36,  10'd37,  10'd39,  10'd40,  10'd42,
    10'd43,  10'd45,  10'd46,  10'd48,  10'd50,  10'd52,  10'd53,  10'd55,
    10'd57,  10'd59,  10'd61,  10'd62,  10'd64,  10'd66,  10'd68,
    10'd70,  10'd72,  10'd75,  10'd77,  10'd79,  10'd81,  10'd83,  10'd85,
    10'd88,  10'd90,  10'd92,  10'd95,  10'd97,  10'd100, 10'd102,
    10'd105, 10'd107, 10'd110, 10'd112, 10'd115, 10'd118, 10'd121, 10'd123,
    10'd126, 10'd129, 10'd132, 10'd135, 10'd138, 10'd141, 10'd144,
    10'd147, 10'd150, 10'd153, 10'd156, 10'd159, 10'd162, 10'd166, 10'd169,
    10'd172, 10'd175, 10'd179, 10'd182, 10'd186, 10'd189, 10'd193,
    10'd196, 10'd200, 10'd203, 10'd207, 10'd211, 10'd215, 10'd218, 10'd222,
    10'd226, 10'd230, 10'd234, 10'd238, 10'd242, 10'd246, 10'd250,
    10'd254, 10'd258, 10'd262, 10'd266, 10'd271, 10'd275, 10'd279, 10'd284,
    10'd288, 10'd292, 10'd297, 10'd301, 10'd306, 10'd311, 10'd315,
    10'd320, 10'd324, 10'd329, 10'd334, 10'd339, 10'd344, 10'd348, 10'd353,
    10'd358, 10'd363, 10'd368, 10'd373, 10'd378, 10'd384, 10'd389,
    10'd394, 10'd399, 10'd405, 10'd410, 10'd415, 10'd421, 10'd426, 10'd432,
    10'd437, 10'd443, 10'd448, 10'd454, 10'd459, 10'd465, 10'd471,
    10'd477, 10'd483, 10'd488, 10'd494, 10'd500, 10'd506, 10'd512, 10'd518,
    10'd524, 10'd530, 10'd537, 10'd543, 10'd549, 10'd555, 10'd562,
    10'd568, 10'd575, 10'd581, 10'd587, 10'd594, 10'd601, 10'd607, 10'd614,
    10'd620, 10'd627, 10'd634, 10'd641, 10'd648, 10'd654, 10'd661,
    10'd668, 10'd675, 10'd682, 10'd689, 10'd697, 10'd704, 10'd711, 10'd718,
    10'd725, 10'd733, 10'd740, 10'd747, 10'd755, 10'd762, 10'd770,
    10'd777, 10'd785, 10'd793, 10'd800, 10'd808, 10'd816, 10'd824, 10'd831,
    10'd839, 10'd847, 10'd855, 10'd863, 10'd871, 10'd879, 10'd887,
    10'd896, 10'd904, 10'd912, 10'd920, 10'd929, 10'd937, 10'd945, 10'd954,
    10'd962, 10'd971, 10'd980, 10'd988, 10'd997, 10'd1005, 10'd1014,
    10'd1023
  };

  function automatic logic [2:0] battery_level(input logic [9:0] code);
    logic [18:0] prod;
    logic [8:0]  cv;
    logic [2:0]  lvl;
    prod = 19'(code) * CV_SCALE;
    cv = prod[18:10];
    if (cv <= CV_LEVEL1) begin
      lvl = 3'd1;
    end else if (cv <= CV_LEVEL2) begin
      lvl = 3'd2;
    end else if (cv <= CV_LEVEL3) begin
      lvl = 3'd3;
    end else if (cv <= CV_LEVEL4) begin
      lvl = 3'd4;
    end else if (cv <= CV_LEVEL5) begin
      lvl = 3'd5;
    end else begin
      lvl = 3'd6;
    end
    return lvl;
  endfunction

endpackage

// ===== design/lmc_cfg_regs.sv =====
module lmc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [lmc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [lmc_pkg::CfgDataW-1:0]  cfg_data_i,
  output lmc_pkg::cfg_t                 cfg_o
);
  import lmc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FADE_INTERVAL: cfg_d.fade_interval_ms = cfg_data_i[7:0];
        CFG_FADE_FLOOR:    cfg_d.fade_floor_index = cfg_data_i[7:0];
        CFG_ON_BRIGHTNESS: cfg_d.on_brightness = cfg_data_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fade_interval_ms <= FADE_INTERVAL_RST;
      cfg_q.fade_floor_index <= FADE_FLOOR_RST;
      cfg_q.on_brightness <= ON_BRIGHTNESS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/lmc_in_reg.sv =====
module lmc_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  lmc_pkg::tick_t tick_i,
  input  logic           advance_i,
  output logic           valid_o,
  output lmc_pkg::tick_t tick_o
);
  import lmc_pkg::*;

  logic  valid_q, valid_d;
  tick_t tick_q;

  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      tick_q <= tick_i;
    end
  end

  assign valid_o = valid_q;
  assign tick_o = tick_q;

endmodule

// ===== design/lmc_mode_fsm.sv =====
module lmc_mode_fsm (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  lmc_pkg::tick_t   tick_i,
  input  lmc_pkg::cfg_t    cfg_i,
  output lmc_pkg::result_t result_o
);
  import lmc_pkg::*;

  lamp_mode_e mode_q, mode_d;
  logic [9:0] pwm_q, pwm_d;
  logic [7:0] idx_q, idx_d;
  logic       rising_q, rising_d;
  logic [7:0] elapsed_q, elapsed_d;
  logic [2:0] shown_q, shown_d;

  logic [7:0] elapsed_inc;
  logic       fade_step;
  logic [7:0] idx_up;
  logic [7:0] idx_dn;

  always_comb begin
    elapsed_inc = (elapsed_q != ELAPSED_MAX) ? elapsed_q + 8'd1 : elapsed_q;
    fade_step = elapsed_inc > cfg_i.fade_interval_ms;
    idx_up = (idx_q != FADE_TOP) ? idx_q + 8'd1 : idx_q;
    idx_dn = (idx_q != 8'd0) ? idx_q - 8'd1 : idx_q;

    mode_d = mode_q;
    pwm_d = pwm_q;
    idx_d = idx_q;
    rising_d = rising_q;
    elapsed_d = elapsed_q;
    shown_d = shown_q;

    if (step_i) begin
      case (mode_q)
        MODE_BARGRAPH: begin
          if (tick_i.release_event) begin
            mode_d = MODE_WHITE;
            pwm_d = cfg_i.on_brightness;
          end
        end
        MODE_WHITE: begin
          if (tick_i.release_event) begin
            mode_d = MODE_RED;
            pwm_d = 10'd0;
          end else if (tick_i.long_press) begin
            mode_d = MODE_FADE;
            idx_d = FADE_TOP;
            rising_d = 1'b0;
            elapsed_d = 8'd0;
          end
        end
        MODE_RED: begin
          if (tick_i.press_event) begin
            mode_d = tick_i.release_event ? MODE_IDLE : MODE_WAIT;
          end
        end
        MODE_FADE: begin
          if (fade_step) begin
            pwm_d = GAMMA_ROM[idx_q];
            elapsed_d = 8'd0;
            if (rising_q) begin
              idx_d = idx_up;
              if (idx_up == FADE_TOP) begin
                rising_d = 1'b0;
              end
            end else begin
              idx_d = idx_dn;
              if (idx_dn <= cfg_i.fade_floor_index) begin
                rising_d = 1'b1;
              end
            end
          end else begin
            elapsed_d = elapsed_inc;
          end
          if (tick_i.release_event) begin
            mode_d = MODE_WHITE;
          end
        end
        MODE_WAIT: begin
          if (tick_i.release_event) begin
            mode_d = MODE_IDLE;
          end
        end
        default: begin
          mode_d = MODE_IDLE;
          if (tick_i.press_event) begin
            mode_d = MODE_BARGRAPH;
            shown_d = battery_level(tick_i.battery_code);
          end
        end
      endcase
    end

    result_o.mode = mode_d;
    result_o.white_enable = (mode_d == MODE_WHITE) || (mode_d == MODE_FADE);
    result_o.white_level = pwm_d;
    result_o.red_enable = (mode_d == MODE_RED);
    result_o.bargraph_enable = (mode_d == MODE_BARGRAPH);
    result_o.bargraph_level = (mode_d == MODE_BARGRAPH) ? shown_d : 3'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      pwm_q <= 10'd0;
      idx_q <= 8'd0;
      rising_q <= 1'b1;
      elapsed_q <= 8'd0;
      shown_q <= 3'd0;
    end else begin
      mode_q <= mode_d;
      pwm_q <= pwm_d;
      idx_q <= idx_d;
      rising_q <= rising_d;
      elapsed_q <= elapsed_d;
      shown_q <= shown_d;
    end
  end

endmodule

// ===== design/lantern_mode_controller.sv =====
// Lamp mode controller for a lantern: every input word is one millisecond tick
// with button events and a battery code, and every tick produces exactly one
// output word with the mode and LED drive after that tick. A tick is taken in
// every clock cycle unless the input stalls; it passes an input register and
// then a result register, from which its output word is offered, and the input
// stalls only while the result register holds a word the consumer has not
// taken. Configuration writes complete in the cycle they are presented and
// should be made only while no tick is in flight.
module lantern_mode_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          press_event_i,
  input  logic                          release_event_i,
  input  logic                          long_press_i,
  input  logic [9:0]                    battery_code_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    mode_o,
  output logic                          white_enable_o,
  output logic [9:0]                    white_level_o,
  output logic                          red_enable_o,
  output logic                          bargraph_enable_o,
  output logic [2:0]                    bargraph_level_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lmc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [lmc_pkg::CfgDataW-1:0]  cfg_data_i
);
  import lmc_pkg::*;

  cfg_t    cfg;
  tick_t   tick_in;
  tick_t   tick_reg;
  logic    tick_valid;
  logic    advance;
  result_t result_next;
  result_t result_q;
  logic    out_valid_q, out_valid_d;

  assign cfg_ready_o = 1'b1;

  lmc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign tick_in.press_event = press_event_i;
  assign tick_in.release_event = release_event_i;
  assign tick_in.long_press = long_press_i;
  assign tick_in.battery_code = battery_code_i;

  assign advance = tick_valid && (!out_valid_q || out_ready_i);

  lmc_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .tick_i     (tick_in),
    .advance_i  (advance),
    .valid_o    (tick_valid),
    .tick_o     (tick_reg)
  );

  lmc_mode_fsm u_mode_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .tick_i   (tick_reg),
    .cfg_i    (cfg),
    .result_o (result_next)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_next;
    end
  end

  assign out_valid_o = out_valid_q;
  assign mode_o = result_q.mode;
  assign white_enable_o = result_q.white_enable;
  assign white_level_o = result_q.white_level;
  assign red_enable_o = result_q.red_enable;
  assign bargraph_enable_o = result_q.bargraph_enable;
  assign bargraph_level_o = result_q.bargraph_level;

  // A held tick must not be overwritten while the result register is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_valid && out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input register accepts a word while the output is stalled");

  // At most one light source is driven at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({white_enable_o, red_enable_o, bargraph_enable_o}))
    else $error("more than one light source enabled");

  // The bargraph always shows a battery level of one or more.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && bargraph_enable_o) |-> (bargraph_level_o != 3'd0))
    else $error("bargraph enabled with an empty level");

  // A stalled output word keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(result_q))
    else $error("result register changed while stalled");

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
  import lmc_pkg::*;

  localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned WORDS_PER_BLOCK = 64;

  // Lamp behaviour predictor and store of the output words still due.
  class lamp_scoreboard;
    lamp_mode_e lamp;
    logic [9:0] pwm;
    logic [7:0] idx;
    bit         rising;
    logic [7:0] elapsed;
    logic [2:0] shown;
    logic [7:0] step_ivl;
    logic [7:0] floor_idx;
    logic [9:0] bright;
    result_t    due_q[$];
    int         errors;

    function void clear();
      lamp = MODE_IDLE;
      pwm = '0;
      idx = '0;
      rising = 1'b1;
      elapsed = '0;
      shown = '0;
      step_ivl = FADE_INTERVAL_RST;
      floor_idx = FADE_FLOOR_RST;
      bright = ON_BRIGHTNESS_RST;
      due_q.delete();
      errors = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] sel, logic [CfgDataW-1:0] data);
      case (sel)
        CFG_FADE_INTERVAL: step_ivl = data[7:0];
        CFG_FADE_FLOOR:    floor_idx = data[7:0];
        CFG_ON_BRIGHTNESS: bright = data;
        default: ;
      endcase
    endfunction

    function logic [2:0] level_of(logic [9:0] code);
      int unsigned centivolts;
      centivolts = (int'(code) * int'(CV_SCALE)) >> 10;
      if (centivolts <= CV_LEVEL1) return 3'd1;
      if (centivolts <= CV_LEVEL2) return 3'd2;
      if (centivolts <= CV_LEVEL3) return 3'd3;
      if (centivolts <= CV_LEVEL4) return 3'd4;
      if (centivolts <= CV_LEVEL5) return 3'd5;
      return 3'd6;
    endfunction

    function void step_fade();
      if (elapsed < ELAPSED_MAX) elapsed++;
      if (elapsed > step_ivl) begin
        pwm = GAMMA_ROM[idx];
        elapsed = '0;
        if (rising) begin
          if (idx < FADE_TOP) idx++;
          if (idx == FADE_TOP) rising = 1'b0;
        end else begin
          if (idx > 0) idx--;
          if (idx <= floor_idx) rising = 1'b1;
        end
      end
    endfunction

    function void note_tick(tick_t t);
      result_t r;
      case (lamp)
        MODE_BARGRAPH: begin
          if (t.release_event) begin
            lamp = MODE_WHITE;
            pwm = bright;
          end
        end
        MODE_WHITE: begin
          if (t.release_event) begin
            lamp = MODE_RED;
            pwm = '0;
          end else if (t.long_press) begin
            lamp = MODE_FADE;
            idx = FADE_TOP;
            rising = 1'b0;
            elapsed = '0;
          end
        end
        MODE_RED: begin
          if (t.press_event) lamp = t.release_event ? MODE_IDLE : MODE_WAIT;
        end
        MODE_FADE: begin
          step_fade();
          if (t.release_event) lamp = MODE_WHITE;
        end
        MODE_WAIT: begin
          if (t.release_event) lamp = MODE_IDLE;
        end
        default: begin
          lamp = MODE_IDLE;
          if (t.press_event) begin
            lamp = MODE_BARGRAPH;
            shown = level_of(t.battery_code);
          end
        end
      endcase
      r.mode = lamp;
      r.white_enable = (lamp == MODE_WHITE) || (lamp == MODE_FADE);
      r.white_level = pwm;
      r.red_enable = (lamp == MODE_RED);
      r.bargraph_enable = (lamp == MODE_BARGRAPH);
      r.bargraph_level = (lamp == MODE_BARGRAPH) ? shown : 3'd0;
      due_q.push_back(r);
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_q.size() == 0) begin
        $display("%0t: output word with nothing due, mode %0d", $time, got.mode);
        errors++;
        return;
      end
      want = due_q.pop_front();
      compare("mode", want.mode, got.mode);
      compare("white_enable", want.white_enable, got.white_enable);
      compare("white_level", want.white_level, got.white_level);
      compare("red_enable", want.red_enable, got.red_enable);
      compare("bargraph_enable", want.bargraph_enable, got.bargraph_enable);
      compare("bargraph_level", want.bargraph_level, got.bargraph_level);
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                pressed = 1'b0;
  logic                released = 1'b0;
  logic                long_press = 1'b0;
  logic [9:0]          battery_code = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [2:0]          mode;
  logic                white_enable;
  logic [9:0]          white_level;
  logic                red_enable;
  logic                bargraph_enable;
  logic [2:0]          bargraph_level;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  lamp_scoreboard sb = new();
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_idle_pct = 0;
  bit             hold_req = 1'b0;
  int unsigned    hold_len = 0;
  int unsigned    cycles = 0;

  lantern_mode_controller dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .press_event_i    (pressed),
    .release_event_i  (released),
    .long_press_i     (long_press),
    .battery_code_i   (battery_code),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .mode_o           (mode),
    .white_enable_o   (white_enable),
    .white_level_o    (white_level),
    .red_enable_o     (red_enable),
    .bargraph_enable_o(bargraph_enable),
    .bargraph_level_o (bargraph_level),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("lantern_mode_controller verification failed");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    result_t r;
    if (rst_n && out_valid && out_ready) begin
      r.mode = lamp_mode_e'(mode);
      r.white_enable = white_enable;
      r.white_level = white_level;
      r.red_enable = red_enable;
      r.bargraph_enable = bargraph_enable;
      r.bargraph_level = bargraph_level;
      sb.check_result(r);
    end
  end

  function automatic tick_t mk(bit p, bit r, bit l, logic [9:0] code);
    tick_t t;
    t.press_event = p;
    t.release_event = r;
    t.long_press = l;
    t.battery_code = code;
    return t;
  endfunction

  // Mostly well-formed button sequences for the current mode, with some noise.
  function automatic tick_t random_tick();
    tick_t t;
    t = mk(1'b0, 1'b0, 1'b0, '0);
    t.battery_code = ($urandom_range(1) != 0) ? 10'($urandom_range(1023, 700))
                                              : 10'($urandom);
    if ($urandom_range(99) < 12) begin
      t.press_event = 1'($urandom_range(1));
      t.release_event = 1'($urandom_range(1));
      t.long_press = 1'($urandom_range(1));
    end else begin
      case (sb.lamp)
        MODE_BARGRAPH: begin
          t.release_event = ($urandom_range(99) < 40);
          t.press_event = ($urandom_range(99) < 20);
        end
        MODE_WHITE: begin
          t.release_event = ($urandom_range(99) < 15);
          t.long_press = ($urandom_range(99) < 30);
        end
        MODE_RED: begin
          t.press_event = ($urandom_range(99) < 35);
          t.release_event = ($urandom_range(99) < 35);
        end
        MODE_FADE: begin
          t.release_event = ($urandom_range(99) < 4);
          t.long_press = 1'($urandom_range(1));
        end
        MODE_WAIT: begin
          t.release_event = ($urandom_range(99) < 35);
          t.press_event = ($urandom_range(99) < 20);
        end
        default: t.press_event = ($urandom_range(99) < 40);
      endcase
    end
    return t;
  endfunction

  task automatic send_tick(input tick_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pressed <= t.press_event;
    released <= t.release_event;
    long_press <= t.long_press;
    battery_code <= t.battery_code;
    do @(posedge clk); while (!in_ready);
    sb.note_tick(t);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] sel, input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(sel, data);
  endtask

  task automatic apply_settings(input logic [9:0] ivl, input logic [9:0] flr,
                                input logic [9:0] brt);
    write_reg(CFG_FADE_INTERVAL, ivl);
    write_reg(CFG_FADE_FLOOR, flr);
    write_reg(CFG_ON_BRIGHTNESS, brt);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [9:0] ivl_set [6];
    logic [9:0] flr_set [6];
    logic [9:0] brt_set [6];
    ivl_set = '{10'd0, 10'd1, 10'h3FF, 10'd0, 10'd2, 10'd0};
    flr_set = '{10'd0, 10'd200, 10'd254, 10'd254, 10'd128, 10'd240};
    brt_set = '{10'd0, 10'd512, 10'd1023, 10'd1, 10'd777, 10'd300};
    sb.clear();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    write_reg(CFG_SPARE, 10'h155);
    write_reg(CFG_FADE_INTERVAL, 10'd0);
    write_reg(CFG_FADE_FLOOR, 10'd254);
    cfg_valid <= 1'b0;
    @(posedge clk);

    send_idle_pct = 22;
    recv_idle_pct = 81;
    send_tick(mk(1'b0, 1'b1, 1'b1, 10'h3FF));
    send_tick(mk(1'b1, 1'b0, 1'b0, 10'd0));
    send_tick(mk(1'b0, 1'b1, 1'b0, 10'd0));
    send_tick(mk(1'b0, 1'b0, 1'b1, 10'd0));
    send_tick(mk(1'b0, 1'b0, 1'b0, 10'd0));
    send_tick(mk(1'b0, 1'b0, 1'b0, 10'd0));
    send_tick(mk(1'b0, 1'b1, 1'b1, 10'd0));
    send_tick(mk(1'b0, 1'b1, 1'b1, 10'd0));
    send_tick(mk(1'b1, 1'b1, 1'b0, 10'd0));
    send_tick(mk(1'b1, 1'b0, 1'b0, 10'd748));
    send_tick(mk(1'b1, 1'b0, 1'b1, 10'd748));
    send_tick(mk(1'b0, 1'b1, 1'b0, 10'd0));
    send_tick(mk(1'b0, 1'b1, 1'b0, 10'd0));
    send_tick(mk(1'b0, 1'b1, 1'b1, 10'd0));
    send_tick(mk(1'b1, 1'b0, 1'b0, 10'd0));
    send_tick(mk(1'b1, 1'b0, 1'b1, 10'd0));
    send_tick(mk(1'b0, 1'b1, 1'b0, 10'd0));
    send_tick(mk(1'b1, 1'b0, 1'b0, 10'd794));
    send_tick(mk(1'b1, 1'b1, 1'b1, 10'd0));
    send_tick(mk(1'b0, 1'b0, 1'b1, 10'd0));
    send_tick(mk(1'b0, 1'b1, 1'b0, 10'd0));
    send_tick(mk(1'b0, 1'b1, 1'b0, 10'd0));
    send_tick(mk(1'b1, 1'b1, 1'b0, 10'd0));
    send_tick(mk(1'b1, 1'b0, 1'b0, 10'd1023));

    // The lamp mode carries over from block to block, so a new floor can land mid-fade.
    for (int blk = 0; blk < 6; blk++) begin
      drain();
      apply_settings(ivl_set[blk], flr_set[blk], brt_set[blk]);
      send_idle_pct = (blk < 2) ? 22 : (blk < 4) ? 81 : 0;
      recv_idle_pct = (blk < 2) ? 81 : (blk < 4) ? 22 : 0;
      for (int n = 0; n < WORDS_PER_BLOCK; n++) begin
        if (blk == 1 && n == 10) begin
          hold_len = 60;
          hold_req = 1'b1;
        end
        if (blk == 3 && n == 32) begin
          in_valid <= 1'b0;
          do @(posedge clk); while (sb.pending() != 0);
        end
        send_tick(random_tick());
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("lantern_mode_controller verification clean");
    end else begin
      $display("lantern_mode_controller verification failed");
    end
    $finish;
  end

endmodule
